// File: rtl/core/mtbp_pkg.sv
// shared types and constants of the msb-first token bit packer
// no dependencies; every other file of the block imports it
package mtbp_pkg;

    localparam int TOKEN_W     = 64;
    localparam int WIDTH_W     = 7;
    localparam int LIMIT_W     = 16;
    localparam int BITS_W      = 19;
    localparam int PART_W      = 7;
    localparam int STREAM_W    = TOKEN_W + PART_W;
    localparam int NBITS_W     = 7;
    localparam int RESULTS_W   = 4;
    localparam int CFG_DATA_W  = 16;
    localparam int QUEUE_DEPTH_DFLT = 2;

    localparam logic [WIDTH_W-1:0] TOKEN_WIDTH_MAX   = 7'd64;
    localparam logic [WIDTH_W-1:0] TOKEN_WIDTH_RESET = 7'd8;
    localparam logic [LIMIT_W-1:0] BYTE_LIMIT_RESET  = 16'hFFFF;

    typedef enum logic [0:0] {
        CFG_TOKEN_WIDTH = 1'b0,
        CFG_BYTE_LIMIT  = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [WIDTH_W-1:0] token_width;
        logic [LIMIT_W-1:0] byte_limit;
    } t_cfg;

    typedef struct packed {
        logic [TOKEN_W-1:0] token_value;
        logic               last_token;
    } t_in;

    typedef struct packed {
        logic [7:0]        byte_value;
        logic              byte_valid;
        logic              end_of_packet;
        logic [BITS_W-1:0] total_bits;
        logic              truncated;
    } t_out;

    // one classified token: its bit stream right aligned plus bookkeeping
    typedef struct packed {
        logic [STREAM_W-1:0]  stream;
        logic [NBITS_W-1:0]   nbits;
        logic [RESULTS_W-1:0] count;
        logic                 last;
        logic [BITS_W-1:0]    base;
        logic                 trunc;
    } t_job;

endpackage

// File: rtl/core/mtbp_front.sv
// front end: accepts tokens, applies width and byte limit, builds jobs
// depends on mtbp_pkg
module mtbp_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  mtbp_pkg::t_cfg  i_cfg,
    input  logic            i_valid,
    input  mtbp_pkg::t_in   i_data,
    output logic            o_stall,
    input  logic            i_full,
    output logic            o_push,
    output mtbp_pkg::t_job  o_job
);
    import mtbp_pkg::*;

    logic [PART_W-1:0]    r_partial;
    logic [2:0]           r_pcnt;
    logic [BITS_W-1:0]    r_bit_cnt;
    logic                 r_dropped;

    logic [PART_W-1:0]    n_partial;
    logic [2:0]           n_pcnt;
    logic [BITS_W-1:0]    n_bit_cnt;
    logic                 n_dropped;

    logic [WIDTH_W-1:0]   w;
    logic [BITS_W-1:0]    limit;
    logic [BITS_W-1:0]    room;
    logic [WIDTH_W-1:0]   acc;
    logic [WIDTH_W-1:0]   skip;
    logic [TOKEN_W-1:0]   shifted;
    logic [TOKEN_W-1:0]   mask;
    logic [TOKEN_W-1:0]   acc_bits;
    logic [STREAM_W-1:0]  stream;
    logic [NBITS_W-1:0]   nbits;
    logic [RESULTS_W-1:0] full_bytes;
    logic [RESULTS_W-1:0] count;
    logic                 accept;

    always_comb begin
        w     = (i_cfg.token_width > TOKEN_WIDTH_MAX) ? TOKEN_WIDTH_MAX : i_cfg.token_width;
        limit = {i_cfg.byte_limit, 3'b000};
        room  = (r_bit_cnt >= limit) ? '0 : limit - r_bit_cnt;
        acc   = (room < {{(BITS_W-WIDTH_W){1'b0}}, w}) ? room[WIDTH_W-1:0] : w;
        skip  = w - acc;

        // accepted bits are the top acc bits of the w-bit token
        shifted  = i_data.token_value >> skip;
        mask     = ~({TOKEN_W{1'b1}} << acc);
        acc_bits = shifted & mask;
        stream   = ({{TOKEN_W{1'b0}}, r_partial} << acc) | {{PART_W{1'b0}}, acc_bits};
        nbits    = {{(NBITS_W-3){1'b0}}, r_pcnt} + acc;

        full_bytes = nbits[NBITS_W-1:3];
        if (!i_data.last_token) begin
            count = full_bytes;
        end else if (nbits[2:0] != 3'd0) begin
            count = full_bytes + RESULTS_W'(1);
        end else if (full_bytes != '0) begin
            count = full_bytes;
        end else begin
            count = RESULTS_W'(1);  // end marker
        end

        n_dropped = r_dropped | (acc != w);
        n_pcnt    = nbits[2:0];
        n_partial = stream[PART_W-1:0] & ~({PART_W{1'b1}} << nbits[2:0]);
        n_bit_cnt = r_bit_cnt + {{(BITS_W-WIDTH_W){1'b0}}, acc};
    end

    assign accept  = i_valid && !i_full;
    assign o_stall = i_full;
    assign o_push  = accept && (count != '0);

    assign o_job.stream = stream;
    assign o_job.nbits  = nbits;
    assign o_job.count  = count;
    assign o_job.last   = i_data.last_token;
    assign o_job.base   = r_bit_cnt - {{(BITS_W-3){1'b0}}, r_pcnt};
    assign o_job.trunc  = n_dropped;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial <= '0;
            r_pcnt    <= '0;
            r_bit_cnt <= '0;
            r_dropped <= 1'b0;
        end else if (accept) begin
            if (i_data.last_token) begin
                r_partial <= '0;
                r_pcnt    <= '0;
                r_bit_cnt <= '0;
                r_dropped <= 1'b0;
            end else begin
                r_partial <= n_partial;
                r_pcnt    <= n_pcnt;
                r_bit_cnt <= n_bit_cnt;
                r_dropped <= n_dropped;
            end
        end
    end

endmodule

// File: rtl/core/mtbp_queue.sv
// short job queue between front and back, head shown ahead
// depends on mtbp_pkg
module mtbp_queue #(
    parameter int DEPTH = mtbp_pkg::QUEUE_DEPTH_DFLT
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mtbp_pkg::t_job  i_job,
    input  logic            i_pop,
    output mtbp_pkg::t_job  o_head,
    output logic            o_full,
    output logic            o_empty
);
    import mtbp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

// File: rtl/core/mtbp_back.sv
// back end: walks the head job one byte a beat into the output register
// depends on mtbp_pkg
module mtbp_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  mtbp_pkg::t_job  i_head,
    input  logic            i_empty,
    output logic            o_pop,
    output logic            o_valid,
    output mtbp_pkg::t_out  o_data,
    input  logic            i_stall
);
    import mtbp_pkg::*;

    logic                 r_valid;
    t_out                 r_data;
    logic [RESULTS_W-1:0] r_k;

    logic                       load;
    logic                       last_res;
    logic [NBITS_W-1:0]         eight_k;
    logic [NBITS_W-1:0]         rem;
    logic [NBITS_W-1:0]         upto;
    logic [NBITS_W-1:0]         consumed;
    logic [STREAM_W+8-1:0]      ext;
    t_out                       n_data;

    always_comb begin
        load     = !i_empty && (!r_valid || !i_stall);
        last_res = (r_k == i_head.count - RESULTS_W'(1));
        eight_k  = NBITS_W'({r_k, 3'b000});
        rem      = i_head.nbits - eight_k;
        // padding zeros below the stream fill a short final byte
        ext      = {i_head.stream, 8'h00};
        upto     = eight_k + NBITS_W'(8);
        consumed = (upto < i_head.nbits) ? upto : i_head.nbits;

        n_data.byte_value    = ext[rem +: 8];
        n_data.byte_valid    = (i_head.nbits != '0);
        n_data.end_of_packet = i_head.last && last_res;
        n_data.total_bits    = i_head.base + {{(BITS_W-NBITS_W){1'b0}}, consumed};
        n_data.truncated     = i_head.trunc;
    end

    assign o_pop   = load && last_res;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_k     <= '0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_k     <= last_res ? '0 : r_k + RESULTS_W'(1);
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data <= n_data;
        end
    end

endmodule

// File: rtl/core/msb_first_token_bit_packer.sv
// top level of the msb-first token bit packer: config registers and wiring
// depends on mtbp_pkg, mtbp_front, mtbp_queue, mtbp_back
//
// input channel: i_valid / o_stall / i_data carry one token a beat; the low
// token_width bits are appended msb first to the packet's byte stream.
// output channel: o_valid / i_stall / o_data carry one result a beat: a
// finished byte, the zero padded final byte, or an end marker.
// config channel: i_cfg_valid / o_cfg_ready (always high) write token_width
// or byte_limit by index; write only while the block is idle.
// the first result of a token passes through the job queue and then the output
// register. a token yields up to nine results (a 64-bit last token); the back
// end emits one byte per cycle while a job is waiting and the receiver does
// not stall; the front takes a token every cycle while the job queue has room.
// a stalled receiver holds the output register; the queue fills and then
// o_stall rises. synchronous reset empties the queue, clears the packet
// state and returns token_width to 8 and byte_limit to 65535.
module msb_first_token_bit_packer #(
    parameter int QUEUE_DEPTH = mtbp_pkg::QUEUE_DEPTH_DFLT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  mtbp_pkg::t_in                       i_data,
    output logic                                o_stall,
    output logic                                o_valid,
    output mtbp_pkg::t_out                      o_data,
    input  logic                                i_stall,
    input  logic                                i_cfg_valid,
    input  mtbp_pkg::t_cfg_idx                  i_cfg_index,
    input  logic [mtbp_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output logic                                o_cfg_ready
);
    import mtbp_pkg::*;

    t_cfg r_cfg;
    t_job job;
    t_job head;
    logic push;
    logic pop;
    logic full;
    logic empty;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.token_width <= TOKEN_WIDTH_RESET;
            r_cfg.byte_limit  <= BYTE_LIMIT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_TOKEN_WIDTH: r_cfg.token_width <= i_cfg_data[WIDTH_W-1:0];
                CFG_BYTE_LIMIT:  r_cfg.byte_limit  <= i_cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    mtbp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_stall (o_stall),
        .i_full  (full),
        .o_push  (push),
        .o_job   (job)
    );

    mtbp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job),
        .i_pop   (pop),
        .o_head  (head),
        .o_full  (full),
        .o_empty (empty)
    );

    mtbp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_empty (empty),
        .o_pop   (pop),
        .o_valid (o_valid),
        .o_data  (o_data),
        .i_stall (i_stall)
    );

endmodule

// File: rtl/core/mtbp_checker.sv
// port level checks of the bit packer, bound to the top level
// depends on mtbp_pkg and msb_first_token_bit_packer
module mtbp_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            o_valid,
    input  mtbp_pkg::t_out  o_data,
    input  logic            i_stall
);
    import mtbp_pkg::*;

    // a held result beat keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("output beat changed while stalled");

    // every result is a data byte or closes the packet
    a_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.byte_valid |-> o_data.end_of_packet && o_data.byte_value == 8'h00)
        else $error("empty result that is not a clean end marker");

    // a full data byte that does not close a packet ends on a byte boundary
    a_boundary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.end_of_packet |-> o_data.total_bits[2:0] == 3'd0 &&
            o_data.total_bits != '0)
        else $error("mid packet byte off a byte boundary");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

endmodule

bind msb_first_token_bit_packer mtbp_checker u_mtbp_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_valid),
    .o_data  (o_data),
    .i_stall (i_stall)
);

// File: verif/msb_first_token_bit_packer_tb.sv
// self-checking testbench of the msb-first token bit packer
// depends on mtbp_pkg and msb_first_token_bit_packer; predicts each byte beat
// from a local copy of the packing state and checks beats in order
module msb_first_token_bit_packer_tb;
    import mtbp_pkg::*;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    t_in                   i_data = '0;
    logic                  o_stall;
    logic                  o_valid;
    t_out                  o_data;
    logic                  i_stall = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    t_cfg_idx              i_cfg_index = CFG_TOKEN_WIDTH;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  o_cfg_ready;

    msb_first_token_bit_packer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_data      (i_data),
        .o_stall     (o_stall),
        .o_valid     (o_valid),
        .o_data      (o_data),
        .i_stall     (i_stall),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready)
    );

    always #4 i_clk = ~i_clk;

    // packing state as the block should hold it
    logic [WIDTH_W-1:0] cfg_width   = TOKEN_WIDTH_RESET;
    logic [LIMIT_W-1:0] cfg_limit   = BYTE_LIMIT_RESET;
    logic [7:0]         pend_byte   = '0;
    logic [3:0]         pend_count  = '0;
    logic [19:0]        pkt_bits    = '0;
    logic               pkt_dropped = 1'b0;

    t_in  tokens_to_send [$];
    t_out bytes_due [$];
    int   n_pushed   = 0;
    int   n_accepted = 0;
    int   n_results  = 0;
    int   errors     = 0;
    bit   idle_on    = 1'b1;
    int   send_gap   = 0;
    int   stall_left = 0;
    int   hold_left  = 0;
    bit   held       = 1'b0;

    function automatic t_out make_byte(logic [7:0] val, logic valid, logic eop,
                                       logic [19:0] bits);
        t_out r;
        r.byte_value    = val;
        r.byte_valid    = valid;
        r.end_of_packet = eop;
        r.total_bits    = bits[BITS_W-1:0];
        r.truncated     = 1'b0;
        return r;
    endfunction

    // append one token msb first and queue the byte beats it yields
    function automatic void pack_token(t_in tok);
        int          w;
        logic [19:0] cap;
        t_out        res [$];
        w   = (cfg_width > TOKEN_WIDTH_MAX) ? 64 : int'(cfg_width);
        cap = {1'b0, cfg_limit, 3'b000};
        for (int b = w; b > 0; b--) begin
            if (pkt_bits >= cap) begin
                pkt_dropped = 1'b1;
            end else begin
                pend_byte  = {pend_byte[6:0], tok.token_value[b-1]};
                pend_count = pend_count + 4'd1;
                pkt_bits   = pkt_bits + 20'd1;
                if (pend_count == 4'd8) begin
                    res.push_back(make_byte(pend_byte, 1'b1, 1'b0, pkt_bits));
                    pend_byte  = '0;
                    pend_count = '0;
                end
            end
        end
        if (tok.last_token) begin
            if (pend_count != 4'd0)
                res.push_back(make_byte(pend_byte << (4'd8 - pend_count), 1'b1, 1'b1,
                                        pkt_bits));
            else if (res.size() > 0)
                res[res.size()-1].end_of_packet = 1'b1;
            else
                res.push_back(make_byte(8'h00, 1'b0, 1'b1, pkt_bits));
        end
        foreach (res[k]) begin
            res[k].truncated = pkt_dropped;
            bytes_due.push_back(res[k]);
        end
        if (tok.last_token) begin
            pend_byte   = '0;
            pend_count  = '0;
            pkt_bits    = '0;
            pkt_dropped = 1'b0;
        end
    endfunction

    function automatic void check_field(string name, logic [BITS_W-1:0] want,
                                        logic [BITS_W-1:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t mismatch %s: expected %0h actual %0h", $time, name, want, got);
        end
    endfunction

    // token sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                pack_token(i_data);
                n_accepted++;
            end
            if (i_valid && o_stall) begin
                // stalled beat holds
            end else if (send_gap > 0) begin
                send_gap--;
                i_valid <= 1'b0;
            end else if (tokens_to_send.size() > 0) begin
                if (idle_on && $urandom_range(0, 3) == 0) begin
                    send_gap = $urandom_range(0, 4);
                    i_valid <= 1'b0;
                end else begin
                    i_valid <= 1'b1;
                    i_data  <= tokens_to_send.pop_front();
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // byte receiver stall, with one long hold-off so the block backs up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (!held && n_results >= 150) begin
            held      = 1'b1;
            hold_left = 99;
            i_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else if (idle_on && $urandom_range(0, 3) == 0) begin
            stall_left = $urandom_range(0, 4);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // byte beat checker
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_valid && !i_stall) begin
            n_results++;
            if (bytes_due.size() == 0) begin
                errors++;
                $display("%0t unexpected beat: expected none actual %h", $time, o_data);
            end else begin
                want = bytes_due.pop_front();
                check_field("byte_value", BITS_W'(want.byte_value), BITS_W'(o_data.byte_value));
                check_field("byte_valid", BITS_W'(want.byte_valid), BITS_W'(o_data.byte_valid));
                check_field("end_of_packet", BITS_W'(want.end_of_packet),
                            BITS_W'(o_data.end_of_packet));
                check_field("total_bits", want.total_bits, o_data.total_bits);
                check_field("truncated", BITS_W'(want.truncated), BITS_W'(o_data.truncated));
            end
        end
    end

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_TOKEN_WIDTH)
            cfg_width = val[WIDTH_W-1:0];
        else
            cfg_limit = val;
        @(posedge i_clk);
    endtask

    function automatic void send_token(logic [TOKEN_W-1:0] v, logic last);
        t_in t;
        t.token_value = v;
        t.last_token  = last;
        tokens_to_send.push_back(t);
        n_pushed++;
    endfunction

    // all tokens taken and all bytes seen, then let tokens with no bytes drain
    task automatic wait_idle();
        while (n_accepted != n_pushed || bytes_due.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    initial begin
        int                 pkt_left;
        logic [WIDTH_W-1:0] tw;
        logic [LIMIT_W-1:0] bl;
        logic [8:0]         hi;
        pkt_left = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset values; three full bytes, end flag lands on the last of them
        send_token(64'hA5, 1'b0);
        send_token('1, 1'b0);
        send_token(64'h0, 1'b1);
        wait_idle();
        write_reg(CFG_TOKEN_WIDTH, 16'd64);
        send_token('1, 1'b0);
        send_token(64'h0, 1'b0);
        send_token(64'h8000_0000_0000_0001, 1'b1);
        wait_idle();
        // padded final byte
        write_reg(CFG_TOKEN_WIDTH, 16'd3);
        send_token(64'd5, 1'b0);
        send_token(64'd2, 1'b0);
        send_token(64'd7, 1'b1);
        wait_idle();
        // zero width gives only an end marker
        write_reg(CFG_TOKEN_WIDTH, 16'd0);
        send_token({$urandom, $urandom}, 1'b1);
        wait_idle();
        // widths above 64 clamp
        write_reg(CFG_TOKEN_WIDTH, 16'd100);
        send_token({$urandom, $urandom}, 1'b1);
        wait_idle();
        write_reg(CFG_TOKEN_WIDTH, 16'hFF7F);
        send_token({$urandom, $urandom}, 1'b1);
        wait_idle();
        // one byte of room, rest dropped
        write_reg(CFG_TOKEN_WIDTH, 16'd16);
        write_reg(CFG_BYTE_LIMIT, 16'd1);
        send_token(64'hABCD, 1'b1);
        wait_idle();
        // no room at all: marker flagged truncated
        write_reg(CFG_TOKEN_WIDTH, 16'd5);
        write_reg(CFG_BYTE_LIMIT, 16'd0);
        send_token(64'h1F, 1'b0);
        send_token(64'h0, 1'b1);
        wait_idle();
        write_reg(CFG_TOKEN_WIDTH, 16'd12);
        write_reg(CFG_BYTE_LIMIT, 16'd2);
        send_token(64'hFFF, 1'b0);
        send_token(64'hABC, 1'b1);
        wait_idle();
        write_reg(CFG_TOKEN_WIDTH, 16'd1);
        write_reg(CFG_BYTE_LIMIT, 16'hFFFF);
        for (int k = 0; k < 7; k++) send_token(64'd1, 1'b0);
        send_token(64'd0, 1'b1);
        wait_idle();

        // random packets under a different setting per phase
        for (int ph = 0; ph < 10; ph++) begin
            idle_on = (ph != 5 && ph != 9);
            case (ph)
                0: tw = 7'd1;
                1: tw = 7'd64;
                2: tw = 7'd0;
                3: tw = 7'd127;
                default: tw = WIDTH_W'($urandom_range(1, 64));
            endcase
            case (ph % 3)
                0: bl = 16'hFFFF;
                1: bl = LIMIT_W'($urandom_range(1, 6));
                default: bl = LIMIT_W'($urandom_range(0, 40));
            endcase
            hi = 9'($urandom_range(0, 511));
            write_reg(CFG_TOKEN_WIDTH, {hi, tw});
            write_reg(CFG_BYTE_LIMIT, bl);
            for (int k = 0; k < 28; k++) begin
                if (pkt_left == 0) pkt_left = $urandom_range(1, 10);
                pkt_left--;
                send_token({$urandom, $urandom}, pkt_left == 0);
            end
            wait_idle();
        end

        if (errors == 0) begin
            $display("PASS msb_first_token_bit_packer");
        end else begin
            $display("FAIL msb_first_token_bit_packer");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("FAIL msb_first_token_bit_packer");
        $finish;
    end
endmodule
